/* rtl/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the pairwise Coulomb step block.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int IDX_W      = 6;
    localparam int SLOT_CODES = 2 ** IDX_W;
    localparam int DT_W       = 16;
    localparam int FRC_W      = 22;      // force and acceleration stay below 2^22
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_OFFSET = 2'd2;

    localparam logic [12:0] WIDTH_RESET  = 13'd1920;
    localparam logic [12:0] HEIGHT_RESET = 13'd1080;
    localparam logic [11:0] FLOOR_RESET  = 12'd300;

    localparam logic [1:0] OUT_LOADED = 2'd0;
    localparam logic [1:0] OUT_FORCE  = 2'd1;
    localparam logic [1:0] OUT_TURN   = 2'd2;
    localparam logic [1:0] OUT_SKIP   = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PAIR = 1'b1;

    // k*q*q / mass in Q16.16
    localparam logic [31:0] KQQ_OVER_MASS = 32'd1178016388;
    // 20 pixels squared in Q32.32
    localparam logic [63:0] NEAR_D2 = 64'd400 << 32;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               neg;
        logic               pin;
    } entry_t;

endpackage

/* rtl/pairwise_coulomb_step.sv */
// ----------------------------------------------------------------------------
// pairwise_coulomb_step
// Particle table with pairwise Coulomb force, near-pair turn and Euler steps
// in Q16.16, sequenced over one shared multiply / divide / root unit.
// ----------------------------------------------------------------------------
//  channel  | signals                                          | handshake
//  ---------+--------------------------------------------------+-------------
//  item in  | kind index_a index_b load_x load_y charge_negative| start, busy
//           | is_pinned delta_time                             |
//  result   | pos_a_x pos_a_y pos_b_x pos_b_y outcome          | done strobe
//  config   | cfg_index cfg_data                               | cfg_write
//
//  A load writes its entry and reports it without the shared unit; a coincident
//  pair stops after the squared distance. Turn and force are set by four
//  divide / square-root passes on the shared unit. An item is taken
//  when start is high and busy low; done marks the result for one cycle and
//  cannot be held off. Reset clears control and restores the wall registers;
//  table entries are undefined until loaded.
// ----------------------------------------------------------------------------
module pairwise_coulomb_step
#(
    parameter int PARTICLE_COUNT = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic [pcs_pkg::IDX_W-1:0]            index_a,
    input  logic [pcs_pkg::IDX_W-1:0]            index_b,
    input  logic signed [31:0]                   load_x,
    input  logic signed [31:0]                   load_y,
    input  logic                                 charge_negative,
    input  logic                                 is_pinned,
    input  logic [pcs_pkg::DT_W-1:0]             delta_time,
    input  logic                                 cfg_write,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 done,
    output logic signed [31:0]                   pos_a_x,
    output logic signed [31:0]                   pos_a_y,
    output logic signed [31:0]                   pos_b_x,
    output logic signed [31:0]                   pos_b_y,
    output logic [1:0]                           outcome
);

    localparam int AW    = $clog2(PARTICLE_COUNT);
    localparam int FRC_W = pcs_pkg::FRC_W;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_RDA, S_RDB, S_CLAMP, S_DIFF,
        S_SX, S_SY, S_SQ,
        S_VX2, S_VY2, S_VSQ, S_NXM, S_NXD, S_NYM, S_NYD,
        S_FD, S_FXM, S_FXD, S_FYM, S_FYD, S_AXM, S_AYM, S_VUPD,
        S_PAX, S_PAY, S_PBX, S_PBY, S_WBA, S_WBB
    } state_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        return (v == 32'sh8000_0000) ? 32'sh7fff_ffff : -v;
    endfunction

    // base +/- mag, saturated to the signed 32-bit range
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                   input logic neg,
                                                   input logic [31:0] mag);
        logic signed [33:0] s;
        logic signed [33:0] m;
        m = $signed({2'b00, mag});
        s = $signed({{2{base[31]}}, base}) + (neg ? -m : m);
        if (s > 34'sh0_7fff_ffff)
            return 32'sh7fff_ffff;
        else if (s < -34'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

    // config
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [11:0] floor_reg;

    // control and results
    state_t          state_reg, state_next;
    logic            pend_reg, pend_next;
    logic            done_reg, done_next;
    logic signed [31:0] rax_reg, rax_next, ray_reg, ray_next;
    logic signed [31:0] rbx_reg, rbx_next, rby_reg, rby_next;
    logic [1:0]      outc_reg, outc_next;

    // datapath
    logic [AW-1:0]   a_reg, a_next, b_reg, b_next;
    logic [pcs_pkg::DT_W-1:0] dt_reg, dt_next;
    pcs_pkg::entry_t ea_reg, ea_next, eb_reg, eb_next;
    logic [31:0]     adx_reg, adx_next, ady_reg, ady_next;
    logic            xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic [63:0]     d2_reg, d2_next;
    logic [31:0]     dist_reg, dist_next;
    logic            near_reg, near_next;
    logic [1:0]      code_reg, code_next;
    logic [63:0]     tmp_reg, tmp_next;
    logic [31:0]     vmag_reg, vmag_next;
    logic [FRC_W-1:0] force_reg, force_next;
    logic [FRC_W-1:0] fx_reg, fx_next, fy_reg, fy_next;
    logic [FRC_W-1:0] mfx_reg, mfx_next, mfy_reg, mfy_next;

    // helpers
    logic [AW-1:0]   slot_tab [pcs_pkg::SLOT_CODES];
    pcs_pkg::entry_t ca;
    logic signed [31:0] wx_s, ylo_s, yhi_s;
    logic signed [32:0] dx, dy, dx_abs, dy_abs;
    logic [64:0]     d2_sum;
    logic [63:0]     d2_sat;
    logic [31:0]     q_sat;
    logic            move_a;

    // table and unit
    logic            tbl_we;
    logic [AW-1:0]   tbl_waddr, tbl_raddr;
    pcs_pkg::entry_t tbl_wdata, tbl_rdata;
    logic            u_go, u_isop, u_done;
    pcs_pkg::op_t    u_op;
    logic [63:0]     u_a, u_b, u_res;

    for (genvar g = 0; g < pcs_pkg::SLOT_CODES; g++)
    begin : g_slot
        assign slot_tab[g] = AW'(g % PARTICLE_COUNT);
    end

    pcs_table #(
        .DEPTH (PARTICLE_COUNT),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    pcs_unit u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (u_go),
        .op     (u_op),
        .opa    (u_a),
        .opb    (u_b),
        .done   (u_done),
        .result (u_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pcs_pkg::WIDTH_RESET;
            height_reg <= pcs_pkg::HEIGHT_RESET;
            floor_reg  <= pcs_pkg::FLOOR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pcs_pkg::CFG_WIDTH_LIMIT:  width_reg  <= cfg_data;
                pcs_pkg::CFG_HEIGHT_LIMIT: height_reg <= cfg_data;
                pcs_pkg::CFG_FLOOR_OFFSET: floor_reg  <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    // walls and clamp of particle a
    always_comb
    begin
        wx_s  = $signed({3'b000, width_reg, 16'd0});
        ylo_s = $signed({4'b0000, floor_reg, 16'd0});
        yhi_s = $signed({2'b00, ({1'b0, height_reg} + {2'b00, floor_reg}), 16'd0});
        ca = ea_reg;
        if (ea_reg.px < 0 || ea_reg.px > wx_s)
        begin
            ca.vx = neg_sat(ea_reg.vx);
            ca.px = (ea_reg.px < 0) ? 32'sd0 : wx_s;
        end
        if (ea_reg.py < ylo_s || ea_reg.py > yhi_s)
        begin
            ca.vy = neg_sat(ea_reg.vy);
            ca.py = (ea_reg.py < ylo_s) ? ylo_s : yhi_s;
        end
    end

    always_comb
    begin
        dx     = $signed({eb_reg.px[31], eb_reg.px}) - $signed({ea_reg.px[31], ea_reg.px});
        dy     = $signed({eb_reg.py[31], eb_reg.py}) - $signed({ea_reg.py[31], ea_reg.py});
        dx_abs = dx[32] ? -dx : dx;
        dy_abs = dy[32] ? -dy : dy;
        d2_sum = {1'b0, tmp_reg} + {1'b0, u_res};
        d2_sat = d2_sum[64] ? '1 : d2_sum[63:0];
        q_sat  = u_res[31] ? 32'h7fff_ffff : u_res[31:0];
        move_a = near_reg || !ea_reg.pin;
    end

    // operand selection for the shared unit
    always_comb
    begin
        u_isop = 1'b1;
        u_op   = pcs_pkg::OP_MUL;
        u_a    = '0;
        u_b    = '0;
        case (state_reg)
            S_SX:  begin u_a = {32'd0, adx_reg}; u_b = {32'd0, adx_reg}; end
            S_SY:  begin u_a = {32'd0, ady_reg}; u_b = {32'd0, ady_reg}; end
            S_SQ:  begin u_op = pcs_pkg::OP_SQRT; u_a = d2_reg; end
            S_VX2: begin u_a = {32'd0, mag32(ea_reg.vx)}; u_b = {32'd0, mag32(ea_reg.vx)}; end
            S_VY2: begin u_a = {32'd0, mag32(ea_reg.vy)}; u_b = {32'd0, mag32(ea_reg.vy)}; end
            S_VSQ: begin u_op = pcs_pkg::OP_SQRT; u_a = tmp_reg; end
            S_NXM: begin u_a = {32'd0, vmag_reg}; u_b = {32'd0, ady_reg}; end
            S_NYM: begin u_a = {32'd0, vmag_reg}; u_b = {32'd0, adx_reg}; end
            S_NXD, S_NYD, S_FXD, S_FYD:
            begin
                u_op = pcs_pkg::OP_DIV;
                u_a  = tmp_reg;
                u_b  = {32'd0, dist_reg};
            end
            S_FD:  begin u_op = pcs_pkg::OP_DIV; u_a = {pcs_pkg::KQQ_OVER_MASS, 32'd0}; u_b = d2_reg; end
            S_FXM: begin u_a = 64'(force_reg); u_b = {32'd0, adx_reg}; end
            S_FYM: begin u_a = 64'(force_reg); u_b = {32'd0, ady_reg}; end
            S_AXM: begin u_a = 64'(fx_reg); u_b = 64'(dt_reg); end
            S_AYM: begin u_a = 64'(fy_reg); u_b = 64'(dt_reg); end
            S_PAX: begin u_a = {32'd0, mag32(ea_reg.vx)}; u_b = 64'(dt_reg); end
            S_PAY: begin u_a = {32'd0, mag32(ea_reg.vy)}; u_b = 64'(dt_reg); end
            S_PBX: begin u_a = {32'd0, mag32(eb_reg.vx)}; u_b = 64'(dt_reg); end
            S_PBY: begin u_a = {32'd0, mag32(eb_reg.vy)}; u_b = 64'(dt_reg); end
            default: u_isop = 1'b0;
        endcase
        u_go = u_isop && !pend_reg;
    end

    always_comb
    begin
        tbl_raddr = (state_reg == S_RDB) ? b_reg : a_reg;
        tbl_we    = (state_reg == S_LOAD) || (state_reg == S_WBA) || (state_reg == S_WBB);
        tbl_waddr = (state_reg == S_WBB) ? b_reg : a_reg;
        tbl_wdata = (state_reg == S_WBB) ? eb_reg : ea_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        done_next  = 1'b0;
        rax_next   = rax_reg;
        ray_next   = ray_reg;
        rbx_next   = rbx_reg;
        rby_next   = rby_reg;
        outc_next  = outc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        dt_next    = dt_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        adx_next   = adx_reg;
        ady_next   = ady_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        d2_next    = d2_reg;
        dist_next  = dist_reg;
        near_next  = near_reg;
        code_next  = code_reg;
        tmp_next   = tmp_reg;
        vmag_next  = vmag_reg;
        force_next = force_reg;
        fx_next    = fx_reg;
        fy_next    = fy_reg;
        mfx_next   = mfx_reg;
        mfy_next   = mfy_reg;

        if (u_go)
            pend_next = 1'b1;
        if (pend_reg && u_done)
            pend_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next  = slot_tab[index_a];
                    b_next  = slot_tab[index_b];
                    dt_next = delta_time;
                    if (kind == pcs_pkg::KIND_LOAD)
                    begin
                        ea_next.px  = load_x;
                        ea_next.py  = load_y;
                        ea_next.vx  = '0;
                        ea_next.vy  = '0;
                        ea_next.neg = charge_negative;
                        ea_next.pin = is_pinned;
                        state_next  = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_RDA;
                    end
                end
            end
            S_LOAD:
            begin
                rax_next   = ea_reg.px;
                ray_next   = ea_reg.py;
                rbx_next   = '0;
                rby_next   = '0;
                outc_next  = pcs_pkg::OUT_LOADED;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_RDA: state_next = S_RDB;
            S_RDB:
            begin
                ea_next    = tbl_rdata;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                ea_next    = ca;
                eb_next    = (a_reg == b_reg) ? ca : tbl_rdata;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                adx_next   = dx_abs[31:0];
                ady_next   = dy_abs[31:0];
                // sign of a's acceleration: away from b, flipped for unlike charges
                xneg_next  = (!dx[32] && dx != 0) ^ (ea_reg.neg ^ eb_reg.neg);
                yneg_next  = (!dy[32] && dy != 0) ^ (ea_reg.neg ^ eb_reg.neg);
                state_next = S_SX;
            end
            S_SX:
                if (pend_reg && u_done) begin tmp_next = u_res; state_next = S_SY; end
            S_SY:
            begin
                if (pend_reg && u_done)
                begin
                    d2_next   = d2_sat;
                    near_next = d2_sat < pcs_pkg::NEAR_D2;
                    if (d2_sat == 64'd0)
                    begin
                        code_next  = pcs_pkg::OUT_SKIP;
                        state_next = S_WBA;
                    end
                    else
                    begin
                        code_next  = (d2_sat < pcs_pkg::NEAR_D2) ? pcs_pkg::OUT_TURN
                                                                 : pcs_pkg::OUT_FORCE;
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                if (pend_reg && u_done)
                begin
                    dist_next  = u_res[31:0];
                    state_next = near_reg ? S_VX2 : S_FD;
                end
            end
            S_VX2:
                if (pend_reg && u_done) begin tmp_next = u_res; state_next = S_VY2; end
            S_VY2:
                if (pend_reg && u_done) begin tmp_next = tmp_reg + u_res; state_next = S_VSQ; end
            S_VSQ:
                if (pend_reg && u_done) begin vmag_next = u_res[31:0]; state_next = S_NXM; end
            S_NXM:
                if (pend_reg && u_done) begin tmp_next = u_res; state_next = S_NXD; end
            S_NXD:
            begin
                if (pend_reg && u_done)
                begin
                    ea_next.vx = -$signed(q_sat);
                    state_next = S_NYM;
                end
            end
            S_NYM:
                if (pend_reg && u_done) begin tmp_next = u_res; state_next = S_NYD; end
            S_NYD:
            begin
                if (pend_reg && u_done)
                begin
                    ea_next.vy = $signed(q_sat);
                    state_next = S_PAX;
                end
            end
            S_FD:
                if (pend_reg && u_done) begin force_next = u_res[FRC_W-1:0]; state_next = S_FXM; end
            S_FXM:
                if (pend_reg && u_done) begin tmp_next = u_res; state_next = S_FXD; end
            S_FXD:
                if (pend_reg && u_done) begin fx_next = u_res[FRC_W-1:0]; state_next = S_FYM; end
            S_FYM:
                if (pend_reg && u_done) begin tmp_next = u_res; state_next = S_FYD; end
            S_FYD:
                if (pend_reg && u_done) begin fy_next = u_res[FRC_W-1:0]; state_next = S_AXM; end
            S_AXM:
            begin
                if (pend_reg && u_done)
                begin
                    mfx_next   = u_res[16 +: FRC_W];
                    state_next = S_AYM;
                end
            end
            S_AYM:
            begin
                if (pend_reg && u_done)
                begin
                    mfy_next   = u_res[16 +: FRC_W];
                    state_next = S_VUPD;
                end
            end
            S_VUPD:
            begin
                if (!ea_reg.pin)
                begin
                    ea_next.vx = sat_add(ea_reg.vx, xneg_reg, 32'(mfx_reg));
                    ea_next.vy = sat_add(ea_reg.vy, yneg_reg, 32'(mfy_reg));
                end
                if (!eb_reg.pin)
                begin
                    eb_next.vx = sat_add(eb_reg.vx, !xneg_reg, 32'(mfx_reg));
                    eb_next.vy = sat_add(eb_reg.vy, !yneg_reg, 32'(mfy_reg));
                end
                state_next = S_PAX;
            end
            S_PAX:
            begin
                if (pend_reg && u_done)
                begin
                    if (move_a)
                        ea_next.px = sat_add(ea_reg.px, ea_reg.vx[31], u_res[47:16]);
                    state_next = S_PAY;
                end
            end
            S_PAY:
            begin
                if (pend_reg && u_done)
                begin
                    if (move_a)
                        ea_next.py = sat_add(ea_reg.py, ea_reg.vy[31], u_res[47:16]);
                    state_next = near_reg ? S_WBA : S_PBX;
                end
            end
            S_PBX:
            begin
                if (pend_reg && u_done)
                begin
                    if (!eb_reg.pin)
                        eb_next.px = sat_add(eb_reg.px, eb_reg.vx[31], u_res[47:16]);
                    state_next = S_PBY;
                end
            end
            S_PBY:
            begin
                if (pend_reg && u_done)
                begin
                    if (!eb_reg.pin)
                        eb_next.py = sat_add(eb_reg.py, eb_reg.vy[31], u_res[47:16]);
                    state_next = S_WBA;
                end
            end
            S_WBA, S_WBB:
            begin
                if (state_reg == S_WBA && code_reg == pcs_pkg::OUT_FORCE)
                begin
                    state_next = S_WBB;
                end
                else
                begin
                    rax_next   = ea_reg.px;
                    ray_next   = ea_reg.py;
                    rbx_next   = eb_reg.px;
                    rby_next   = eb_reg.py;
                    outc_next  = code_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rax_reg   <= '0;
            ray_reg   <= '0;
            rbx_reg   <= '0;
            rby_reg   <= '0;
            outc_reg  <= pcs_pkg::OUT_LOADED;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            rax_reg   <= rax_next;
            ray_reg   <= ray_next;
            rbx_reg   <= rbx_next;
            rby_reg   <= rby_next;
            outc_reg  <= outc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        dt_reg    <= dt_next;
        ea_reg    <= ea_next;
        eb_reg    <= eb_next;
        adx_reg   <= adx_next;
        ady_reg   <= ady_next;
        xneg_reg  <= xneg_next;
        yneg_reg  <= yneg_next;
        d2_reg    <= d2_next;
        dist_reg  <= dist_next;
        near_reg  <= near_next;
        code_reg  <= code_next;
        tmp_reg   <= tmp_next;
        vmag_reg  <= vmag_next;
        force_reg <= force_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        mfx_reg   <= mfx_next;
        mfy_reg   <= mfy_next;
    end

    assign busy    = state_reg != S_IDLE;
    assign done    = done_reg;
    assign pos_a_x = rax_reg;
    assign pos_a_y = ray_reg;
    assign pos_b_x = rbx_reg;
    assign pos_b_y = rby_reg;
    assign outcome = outc_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(tbl_we))
        else $error("result without table write back");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start");

    a_unit_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> pend_reg)
        else $error("unit result with no operation pending");

endmodule

/* rtl/pcs_unit.sv */
// ----------------------------------------------------------------------------
// pcs_unit
// Shared arithmetic unit: 32x32 multiply with a registered product, 64/64 divide with a
// 32-bit quotient and 64-bit floor square root, both one bit per cycle.
// ----------------------------------------------------------------------------
module pcs_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  pcs_pkg::op_t  op,
    input  logic [63:0]   opa,
    input  logic [63:0]   opb,
    output logic          done,
    output logic [63:0]   result
);

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_SQRT
    } ustate_t;

    localparam int STEPS = 32;
    localparam int CNT_W = $clog2(STEPS);

    ustate_t            state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [63:0]        result_reg;
    logic [63:0]        rem_reg;
    logic [31:0]        sh_reg;
    logic [63:0]        dvs_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;

    logic [63:0]        mul_prod;
    logic [64:0]        div_trial;
    logic               div_ge;
    logic [63:0]        div_rem_next;
    logic [31:0]        div_sh_next;
    logic [64:0]        sq_sum;
    logic               sq_ge;
    logic [63:0]        sq_rem_next;
    logic [63:0]        sq_root_next;

    assign mul_prod = opa[31:0] * opb[31:0];

    // restoring divide step; remainder stays below the divisor
    always_comb
    begin
        div_trial    = {rem_reg, sh_reg[31]};
        div_ge       = div_trial >= {1'b0, dvs_reg};
        div_rem_next = div_ge ? 64'(div_trial - {1'b0, dvs_reg}) : div_trial[63:0];
        div_sh_next  = {sh_reg[30:0], div_ge};
    end

    // digit-by-digit root, two radicand bits per step
    always_comb
    begin
        sq_sum       = {1'b0, root_reg} + {1'b0, bit_reg};
        sq_ge        = {1'b0, rem_reg} >= sq_sum;
        sq_rem_next  = sq_ge ? 64'({1'b0, rem_reg} - sq_sum) : rem_reg;
        sq_root_next = sq_ge ? (root_reg >> 1) + bit_reg : root_reg >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                U_IDLE:
                begin
                    if (go)
                    begin
                        cnt_reg <= '0;
                        case (op)
                            pcs_pkg::OP_MUL:
                            begin
                                result_reg <= mul_prod;
                                done_reg   <= 1'b1;
                            end
                            pcs_pkg::OP_DIV:
                            begin
                                rem_reg   <= {32'd0, opa[63:32]};
                                sh_reg    <= opa[31:0];
                                dvs_reg   <= opb;
                                state_reg <= U_DIV;
                            end
                            pcs_pkg::OP_SQRT:
                            begin
                                rem_reg   <= opa;
                                root_reg  <= '0;
                                bit_reg   <= 64'd1 << 62;
                                state_reg <= U_SQRT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                U_DIV:
                begin
                    rem_reg <= div_rem_next;
                    sh_reg  <= div_sh_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(STEPS - 1))
                    begin
                        result_reg <= {32'd0, div_sh_next};
                        done_reg   <= 1'b1;
                        state_reg  <= U_IDLE;
                    end
                end
                U_SQRT:
                begin
                    rem_reg  <= sq_rem_next;
                    root_reg <= sq_root_next;
                    bit_reg  <= bit_reg >> 2;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(STEPS - 1))
                    begin
                        result_reg <= sq_root_next;
                        done_reg   <= 1'b1;
                        state_reg  <= U_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> state_reg == U_IDLE)
        else $error("unit started while iterating");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("unit done held for two cycles");

    a_iter_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != U_IDLE && cnt_reg == CNT_W'(STEPS - 1)) |=> done_reg)
        else $error("iteration ended without done");

endmodule

/* rtl/pcs_table.sv */
// ----------------------------------------------------------------------------
// pcs_table
// Particle table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcs_table
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  pcs_pkg::entry_t   wdata,
    input  logic [AW-1:0]     raddr,
    output pcs_pkg::entry_t   rdata
);

    pcs_pkg::entry_t mem [DEPTH];
    pcs_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* test/tb_pairwise_coulomb_step.sv */
// ----------------------------------------------------------------------------
// tb_pairwise_coulomb_step
// Self-checking bench: a fixed-point predictor of the particle table checks
// every result field; directed corner items come first, then random loads and
// pair interactions under several wall settings and random start gaps.
// ----------------------------------------------------------------------------
module tb_pairwise_coulomb_step;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        kind;
        logic [5:0]  ia;
        logic [5:0]  ib;
        logic [31:0] lx;
        logic [31:0] ly;
        logic        neg;
        logic        pin;
        logic [15:0] dt;
    } item_t;

    typedef struct {
        logic [31:0] pax;
        logic [31:0] pay;
        logic [31:0] pbx;
        logic [31:0] pby;
        logic [1:0]  oc;
    } step_res_t;

    class step_scoreboard;
        int          px[64], py[64], vx[64], vy[64];
        bit          sneg[64], spin[64];
        longint      wall_w, wall_h, wall_f;
        step_res_t   pending_q[$];
        int          errors;

        function new();
            wall_w = pcs_pkg::WIDTH_RESET;
            wall_h = pcs_pkg::HEIGHT_RESET;
            wall_f = pcs_pkg::FLOOR_RESET;
            errors = 0;
        endfunction

        function void set_wall(logic [1:0] idx, logic [12:0] val);
            if (idx == pcs_pkg::CFG_WIDTH_LIMIT) wall_w = val;
            else if (idx == pcs_pkg::CFG_HEIGHT_LIMIT) wall_h = val;
            else if (idx == pcs_pkg::CFG_FLOOR_OFFSET) wall_f = val[11:0];
        endfunction

        function int sat32(longint v);
            if (v > 64'sd2147483647) return 32'h7fffffff;
            if (v < -64'sd2147483648) return 32'h80000000;
            return int'(v);
        endfunction

        function bit [63:0] mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        // v * dt truncated toward zero
        function longint scale_dt(longint v, bit [15:0] dt);
            bit [63:0] p;
            p = (mag(v) * {48'd0, dt}) >> 16;
            return v < 0 ? -longint'(p) : longint'(p);
        endfunction

        function bit [63:0] root(bit [63:0] n);
            bit [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function int neg_sat(int v);
            return v == 32'h80000000 ? 32'h7fffffff : -v;
        endfunction

        function void euler_step(int i, longint ax, longint ay, bit [15:0] dt);
            vx[i] = sat32(longint'(vx[i]) + scale_dt(ax, dt));
            vy[i] = sat32(longint'(vy[i]) + scale_dt(ay, dt));
            px[i] = sat32(longint'(px[i]) + scale_dt(vx[i], dt));
            py[i] = sat32(longint'(py[i]) + scale_dt(vy[i], dt));
        endfunction

        function logic [1:0] pair_step(int a, int b, bit [15:0] dt);
            longint    wx, ylo, yhi, fx, fy;
            bit [63:0] adx, ady, sx, sy, d2, dst_len, va, vb, vm, nx, ny, frc;
            wx  = wall_w <<< 16;
            ylo = wall_f <<< 16;
            yhi = (wall_h + wall_f) <<< 16;
            if (px[a] < 0 || px[a] > wx) begin
                vx[a] = neg_sat(vx[a]);
                px[a] = px[a] < 0 ? 0 : int'(wx);
            end
            if (py[a] < ylo || py[a] > yhi) begin
                vy[a] = neg_sat(vy[a]);
                py[a] = py[a] < ylo ? int'(ylo) : int'(yhi);
            end
            adx = mag(longint'(px[b]) - longint'(px[a]));
            ady = mag(longint'(py[b]) - longint'(py[a]));
            sx = adx * adx;
            sy = ady * ady;
            d2 = (sx > ~64'd0 - sy) ? ~64'd0 : sx + sy;
            if (d2 == 0) return pcs_pkg::OUT_SKIP;
            dst_len = root(d2);
            if (d2 < pcs_pkg::NEAR_D2) begin
                va = mag(vx[a]);
                vb = mag(vy[a]);
                vm = root(va * va + vb * vb);
                nx = vm * ady / dst_len;
                ny = vm * adx / dst_len;
                if (nx > 64'h7fffffff) nx = 64'h7fffffff;
                if (ny > 64'h7fffffff) ny = 64'h7fffffff;
                vx[a] = -int'(nx);
                vy[a] = int'(ny);
                px[a] = sat32(longint'(px[a]) + scale_dt(vx[a], dt));
                py[a] = sat32(longint'(py[a]) + scale_dt(vy[a], dt));
                return pcs_pkg::OUT_TURN;
            end
            frc = ({32'd0, pcs_pkg::KQQ_OVER_MASS} << 32) / d2;
            fx = longint'(frc * adx / dst_len);
            fy = longint'(frc * ady / dst_len);
            if (px[a] < px[b]) fx = -fx;
            if (py[a] < py[b]) fy = -fy;
            if (sneg[a] != sneg[b]) begin
                fx = -fx;
                fy = -fy;
            end
            if (!spin[a]) euler_step(a, fx, fy, dt);
            if (!spin[b]) euler_step(b, -fx, -fy, dt);
            return pcs_pkg::OUT_FORCE;
        endfunction

        function void note_item(item_t it);
            step_res_t r;
            int a, b;
            a = it.ia;
            b = it.ib;
            if (it.kind == pcs_pkg::KIND_LOAD) begin
                px[a] = it.lx;
                py[a] = it.ly;
                vx[a] = 0;
                vy[a] = 0;
                sneg[a] = it.neg;
                spin[a] = it.pin;
                r = '{px[a], py[a], 32'd0, 32'd0, pcs_pkg::OUT_LOADED};
            end
            else begin
                r.oc  = pair_step(a, b, it.dt);
                r.pax = px[a];
                r.pay = py[a];
                r.pbx = px[b];
                r.pby = py[b];
            end
            pending_q = {pending_q, r};
        endfunction

        function void check_result(step_res_t got);
            step_res_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: result with none pending: %h %h %h %h %0d", $realtime,
                         got.pax, got.pay, got.pbx, got.pby, got.oc);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.pax !== e.pax)
                $display("%0t: pos_a_x exp %h got %h", $realtime, e.pax, got.pax);
            if (got.pay !== e.pay)
                $display("%0t: pos_a_y exp %h got %h", $realtime, e.pay, got.pay);
            if (got.pbx !== e.pbx)
                $display("%0t: pos_b_x exp %h got %h", $realtime, e.pbx, got.pbx);
            if (got.pby !== e.pby)
                $display("%0t: pos_b_y exp %h got %h", $realtime, e.pby, got.pby);
            if (got.oc !== e.oc)
                $display("%0t: outcome exp %0d got %0d", $realtime, e.oc, got.oc);
            if (got.pax !== e.pax || got.pay !== e.pay || got.pbx !== e.pbx ||
                got.pby !== e.pby || got.oc !== e.oc)
                errors++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        kind = 1'b0;
    logic [5:0]  index_a = '0;
    logic [5:0]  index_b = '0;
    logic signed [31:0] load_x = '0;
    logic signed [31:0] load_y = '0;
    logic        charge_negative = 1'b0;
    logic        is_pinned = 1'b0;
    logic [15:0] delta_time = '0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        done;
    logic signed [31:0] pos_a_x, pos_a_y, pos_b_x, pos_b_y;
    logic [1:0]  outcome;

    step_scoreboard sb = new();
    bit [63:0]      loaded = '0;
    int             item_no = 0;

    pairwise_coulomb_step dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
        if (done)
            sb.check_result('{pos_a_x, pos_a_y, pos_b_x, pos_b_y, outcome});

    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    task automatic send(item_t it);
        @(negedge clk);
        while (busy)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        kind = it.kind;
        index_a = it.ia;
        index_b = it.ib;
        load_x = it.lx;
        load_y = it.ly;
        charge_negative = it.neg;
        is_pinned = it.pin;
        delta_time = it.dt;
        start = 1'b1;
        @(posedge clk);
        sb.note_item(it);
        if (it.kind == pcs_pkg::KIND_LOAD) loaded[it.ia] = 1'b1;
        item_no++;
    endtask

    task automatic load(int slot, int x, int y, bit neg, bit pin);
        send('{pcs_pkg::KIND_LOAD, slot[5:0], 6'(~slot), x, y, neg, pin, 16'($urandom)});
    endtask

    task automatic pair(int a, int b, bit [15:0] dt);
        send('{pcs_pkg::KIND_PAIR, a[5:0], b[5:0], $urandom, $urandom,
               1'($urandom), 1'($urandom), dt});
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending_q.size() != 0 || busy) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_wall(logic [1:0] idx, logic [12:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.set_wall(idx, val);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    function automatic int pick_loaded();
        int s;
        do s = $urandom_range(63); while (!loaded[s]);
        return s;
    endfunction

    function automatic int rand_pos(int lo_px, int hi_px);
        int r;
        int whole;
        r = $urandom_range(99);
        if (r < 8) return int'($urandom);
        whole = lo_px + int'($urandom_range(hi_px - lo_px));
        return (whole <<< 16) | int'($urandom_range(16'hffff));
    endfunction

    task automatic random_items(int n, bit calm);
        int r, s, a, b;
        for (int k = 0; k < n; k++)
        begin
            if (!calm && $urandom_range(99) < 27)
            begin
                // idle with the block free, so the gap is seen at the input
                @(negedge clk);
                start = 1'b0;
                while (busy) @(negedge clk);
                repeat ($urandom_range(6, 1)) @(negedge clk);
            end
            r = $urandom_range(99);
            if (r < 25 || loaded == 0)
            begin
                s = $urandom_range(63);
                load(s, rand_pos(-200, 2300), rand_pos(100, 1600),
                     1'($urandom_range(1)), $urandom_range(99) < 25);
            end
            else if (r < 35)
            begin
                // drop a particle right next to (or onto) a loaded one
                a = pick_loaded();
                s = $urandom_range(63);
                load(s, sb.px[a] + int'($urandom_range(20 << 16)) - (10 << 16),
                     sb.py[a] + int'($urandom_range(20 << 16)) - (10 << 16),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
                if (s != a) pair(a, s, 16'($urandom));
            end
            else
            begin
                a = pick_loaded();
                b = $urandom_range(99) < 4 ? a : pick_loaded();
                pair(a, b, $urandom_range(99) < 10 ? 16'(16'hffff - $urandom_range(3))
                                                   : 16'($urandom_range(2000)));
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_wall(pcs_pkg::CFG_WIDTH_LIMIT, pcs_pkg::WIDTH_RESET);
        write_wall(pcs_pkg::CFG_HEIGHT_LIMIT, pcs_pkg::HEIGHT_RESET);
        write_wall(pcs_pkg::CFG_FLOOR_OFFSET, 13'(pcs_pkg::FLOOR_RESET));

        // directed corners
        load(0, 100 << 16, 400 << 16, 1'b0, 1'b0);
        load(63, 32'h7fffffff, 32'h80000000, 1'b1, 1'b1);
        load(1, 200 << 16, 400 << 16, 1'b1, 1'b0);
        load(2, 105 << 16, 405 << 16, 1'b0, 1'b0);
        load(3, 100 << 16, 400 << 16, 1'b1, 1'b1);
        load(62, -(5 << 16), -(3 << 16), 1'b0, 1'b1);
        pair(0, 0, 16'hffff);
        pair(0, 3, 16'h1234);
        pair(0, 1, 16'h8000);
        pair(0, 2, 16'hffff);
        pair(1, 0, 16'h0000);
        pair(63, 0, 16'hffff);
        pair(0, 63, 16'h4000);
        pair(62, 1, 16'hffff);
        pair(2, 63, 16'h0000);
        pair(1, 2, 16'h0001);
        pair(0, 2, 16'h00ff);

        drain();
        random_items(250, 1'b0);
        random_items(200, 1'b1);

        drain();
        write_wall(pcs_pkg::CFG_WIDTH_LIMIT, 13'd0);
        write_wall(pcs_pkg::CFG_HEIGHT_LIMIT, 13'd0);
        write_wall(pcs_pkg::CFG_FLOOR_OFFSET, 13'd0);
        random_items(200, 1'b0);

        drain();
        write_wall(pcs_pkg::CFG_WIDTH_LIMIT, 13'h1fff);
        write_wall(pcs_pkg::CFG_HEIGHT_LIMIT, 13'h1fff);
        write_wall(pcs_pkg::CFG_FLOOR_OFFSET, 13'hfff);
        random_items(200, 1'b0);

        drain();
        write_wall(pcs_pkg::CFG_WIDTH_LIMIT, 13'($urandom_range(2500, 400)));
        write_wall(pcs_pkg::CFG_HEIGHT_LIMIT, 13'($urandom_range(1500, 300)));
        write_wall(pcs_pkg::CFG_FLOOR_OFFSET, 13'($urandom_range(500, 0)));
        random_items(230, 1'b0);

        drain();
        repeat (200) @(negedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
